// File: rtl/sphere_point_rotate_project_top_macros.svh
// ----------------------------------------------------------------------------
// Sphere point rotate/project assertion macros
// Concurrent checks on clk with synchronous reset rst; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef SPHERE_POINT_ROTATE_PROJECT_TOP_MACROS_SVH
`define SPHERE_POINT_ROTATE_PROJECT_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SPR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("spr assertion failed");
`define SPR_ASSERT_NEVER(label, expr) \
  `SPR_ASSERT(label, !(expr))
`else
`define SPR_ASSERT(label, prop)
`define SPR_ASSERT_NEVER(label, expr)
`endif

`endif

// File: rtl/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg
// Constants, types, trig table and fixed-point helpers for the sphere point
// rotate/project block.
// ----------------------------------------------------------------------------
package spr_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int SCREEN_SIZE   = 128;

  localparam int IDX_W       = 8;
  localparam int ROM_DEPTH   = 2 ** IDX_W;
  localparam int TRIG_W      = 16;
  localparam int COORD_W     = 18;
  localparam int SUM_W       = COORD_W + TRIG_W + 1;
  localparam int PROJ_W      = 32;
  localparam int SCREEN_W    = 8;
  localparam int IN_DATA_W   = 2 * IDX_W;
  localparam int OUT_DATA_W  = 2 * SCREEN_W;

  localparam int Q14_FRAC = 14;
  localparam int Q14_ONE  = 16384;
  localparam int Q14_HALF = 8192;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_YAW   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PITCH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ROLL  = CFG_IDX_W'(2);

  // Q30 constants for the table build (pi, pi/2 and one)
  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam int TAYLOR_TERMS = 12;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
  } trig_t;

  typedef struct packed {
    trig_t lat;
    trig_t lon;
  } point_t;

  typedef struct packed {
    coord_t p;
    coord_t q;
  } coord_pair_t;

  typedef struct packed {
    logic                  en;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef logic [ROM_DEPTH*2*TRIG_W-1:0] trig_rom_t;

  // Floor quotient by shift and subtract; only evaluated while building the table.
  function automatic longint unsigned table_quot(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Elaboration-time table entry: Taylor series in Q30, folded by quadrant.
  function automatic trig_t trig_entry(int unsigned idx);
    longint unsigned x;
    longint unsigned ts;
    longint unsigned tc;
    longint unsigned a;
    longint          ssum;
    longint          csum;
    longint          rs;
    longint          rc;
    logic            sneg;
    logic            cneg;
    trig_t           res;
    x = table_quot((64'(idx) * 64'd628) << 30, 64'd100 * 64'(TABLE_ENTRIES));
    sneg = 1'b0;
    cneg = 1'b0;
    if (x >= PI_Q30) begin
      x = x - PI_Q30;
      sneg = ~sneg;
      cneg = ~cneg;
    end
    if (x > HALF_PI_Q30) begin
      x = PI_Q30 - x;
      cneg = ~cneg;
    end
    ts = x;
    tc = ONE_Q30;
    ssum = $signed(ts);
    csum = $signed(tc);
    for (int k = 1; k < TAYLOR_TERMS; k++) begin
      a  = 64'(2 * k);
      ts = (ts * x) >> 30;
      ts = table_quot((ts * x) >> 30, a * (a + 64'd1));
      tc = (tc * x) >> 30;
      tc = table_quot((tc * x) >> 30, (a - 64'd1) * a);
      if ((k % 2) == 1) begin
        ssum = ssum - $signed(ts);
        csum = csum - $signed(tc);
      end else begin
        ssum = ssum + $signed(ts);
        csum = csum + $signed(tc);
      end
    end
    if (ssum < 0) ssum = 0;
    if (csum < 0) csum = 0;
    rs = $signed(($unsigned(ssum) + 64'd32768) >> 16);
    rc = $signed(($unsigned(csum) + 64'd32768) >> 16);
    res.s = TRIG_W'(sneg ? -rs : rs);
    res.c = TRIG_W'(cneg ? -rc : rc);
    return res;
  endfunction

  // Table over the raw index space; the wrap to TABLE_ENTRIES is folded in.
  function automatic trig_rom_t build_trig_rom();
    trig_rom_t rom;
    rom = '0;
    for (int v = 0; v < ROM_DEPTH; v++) begin
      rom[v*2*TRIG_W +: 2*TRIG_W] = trig_entry(v % TABLE_ENTRIES);
    end
    return rom;
  endfunction

  localparam trig_rom_t TRIG_ROM = build_trig_rom();

  function automatic trig_t trig_lookup(logic [IDX_W-1:0] idx);
    return trig_t'(TRIG_ROM[idx*2*TRIG_W +: 2*TRIG_W]);
  endfunction

  // floor((v + 2^13) / 2^14)
  function automatic coord_t round_q14(sum_t v);
    sum_t t;
    t = v + SUM_W'(Q14_HALF);
    return COORD_W'(t >>> Q14_FRAC);
  endfunction

  // p = a*c + b*s, q = b*c - a*s
  function automatic coord_pair_t rotate(coord_t a, coord_t b, trig_t t);
    coord_pair_t r;
    r.p = round_q14(SUM_W'(a) * SUM_W'(t.c) + SUM_W'(b) * SUM_W'(t.s));
    r.q = round_q14(SUM_W'(b) * SUM_W'(t.c) - SUM_W'(a) * SUM_W'(t.s));
    return r;
  endfunction

  function automatic logic [SCREEN_W-1:0] project(coord_t v);
    logic signed [PROJ_W-1:0] t;
    logic signed [PROJ_W-1:0] q;
    logic [SCREEN_W-1:0]      res;
    t = (PROJ_W'(v) + PROJ_W'(Q14_ONE)) * PROJ_W'(SCREEN_SIZE);
    q = t >>> (Q14_FRAC + 1);
    if (t < 0) begin
      res = '0;
    end else if (q > PROJ_W'(SCREEN_SIZE)) begin
      res = SCREEN_W'(SCREEN_SIZE);
    end else begin
      res = SCREEN_W'(q);
    end
    return res;
  endfunction

endpackage

// File: rtl/spr_front.sv
// ----------------------------------------------------------------------------
// spr_front
// Input stage: takes lat/lon indices, looks up their sine and cosine and
// hands the point to the queue.
// ----------------------------------------------------------------------------
module spr_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [spr_pkg::IN_DATA_W-1:0]  s_tdata,   // lat_index, lon_index
  output logic                           push_valid,
  input  logic                           push_ready,
  output spr_pkg::point_t                push_item
);

  logic            item_valid;
  spr_pkg::point_t item;

  assign s_tready   = !item_valid || push_ready;
  assign push_valid = item_valid;
  assign push_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.lat <= spr_pkg::trig_lookup(s_tdata[spr_pkg::IDX_W-1:0]);
      item.lon <= spr_pkg::trig_lookup(s_tdata[2*spr_pkg::IDX_W-1:spr_pkg::IDX_W]);
    end
  end

endmodule

// File: rtl/spr_queue.sv
// ----------------------------------------------------------------------------
// spr_queue
// Short FIFO between the lookup front and the arithmetic back.
// ----------------------------------------------------------------------------
module spr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  spr_pkg::point_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output spr_pkg::point_t out_item
);

  spr_pkg::point_t                entries [spr_pkg::QUEUE_DEPTH];
  logic [spr_pkg::QPTR_W-1:0]     wr_ptr;
  logic [spr_pkg::QPTR_W-1:0]     rd_ptr;
  logic [spr_pkg::QCNT_W-1:0]     count;
  logic                           push;
  logic                           pop;

  assign in_ready  = count != spr_pkg::QCNT_W'(spr_pkg::QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_item  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  function automatic logic [spr_pkg::QPTR_W-1:0] ptr_inc(logic [spr_pkg::QPTR_W-1:0] p);
    return (p == spr_pkg::QPTR_W'(spr_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= in_item;
  end

endmodule

// File: rtl/spr_back.sv
// ----------------------------------------------------------------------------
// spr_back
// Arithmetic pipeline: builds the sphere point, applies yaw, pitch and roll,
// projects to the screen. Holds the orientation registers.
// ----------------------------------------------------------------------------
module spr_back (
  input  logic                            clk,
  input  logic                            rst,
  input  spr_pkg::cfg_wr_t                cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  spr_pkg::point_t                 in_item,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [spr_pkg::OUT_DATA_W-1:0]  m_tdata,   // screen_x, screen_y
  output logic                            m_tuser    // visible
);

  spr_pkg::trig_t       yaw_trig;
  spr_pkg::trig_t       pitch_trig;
  spr_pkg::trig_t       roll_trig;

  logic                 v1, v2, v3, v4, v5;
  spr_pkg::coord_t      x1, y1, z1;
  spr_pkg::coord_t      x2, y2, z2;
  spr_pkg::coord_t      x3, y3;
  logic                 vis3;
  spr_pkg::coord_t      x4, y4;
  logic                 vis4;
  logic [spr_pkg::SCREEN_W-1:0] screen_x, screen_y;
  logic                 vis5;
  logic                 en;

  spr_pkg::coord_pair_t yaw_rot, pitch_rot, roll_rot;

  // whole pipeline advances together; stalls only when the output is held
  assign en       = !v5 || m_tready;
  assign in_ready = en;

  assign m_tvalid = v5;
  assign m_tdata  = {screen_y, screen_x};
  assign m_tuser  = vis5;

  assign yaw_rot   = spr_pkg::rotate(x1, z1, yaw_trig);
  assign pitch_rot = spr_pkg::rotate(y2, z2, pitch_trig);
  assign roll_rot  = spr_pkg::rotate(x3, y3, roll_trig);

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_trig   <= spr_pkg::trig_lookup('0);
      pitch_trig <= spr_pkg::trig_lookup('0);
      roll_trig  <= spr_pkg::trig_lookup('0);
    end else if (cfg.en) begin
      case (cfg.index)
        spr_pkg::REG_YAW:   yaw_trig   <= spr_pkg::trig_lookup(cfg.data);
        spr_pkg::REG_PITCH: pitch_trig <= spr_pkg::trig_lookup(cfg.data);
        spr_pkg::REG_ROLL:  roll_trig  <= spr_pkg::trig_lookup(cfg.data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // point on the sphere
      x1 <= spr_pkg::round_q14(spr_pkg::SUM_W'(in_item.lon.s) *
                               spr_pkg::SUM_W'(in_item.lat.c));
      y1 <= spr_pkg::COORD_W'(in_item.lat.s);
      z1 <= spr_pkg::round_q14(spr_pkg::SUM_W'(in_item.lon.c) *
                               spr_pkg::SUM_W'(in_item.lat.c));
      // yaw
      x2 <= yaw_rot.p;
      y2 <= y1;
      z2 <= yaw_rot.q;
      // pitch; the sign of the pitched z gives visibility
      x3   <= x2;
      y3   <= pitch_rot.p;
      vis3 <= !pitch_rot.q[spr_pkg::COORD_W-1];
      // roll
      x4   <= roll_rot.p;
      y4   <= roll_rot.q;
      vis4 <= vis3;
      // projection
      screen_x <= spr_pkg::project(x4);
      screen_y <= spr_pkg::project(y4);
      vis5     <= vis4;
    end
  end

endmodule

// File: rtl/sphere_point_rotate_project_top.sv
// Throughput: one point per cycle while the output is not held, set by
// the five-stage multiply pipeline in the back end (four 18x16
// multipliers per rotation stage).
// A 4-entry queue decouples the lookup front from the back end.
// Reset (synchronous): pipeline and queue empty, yaw/pitch/roll = 0.
// Trig tables are constant logic and need no fill after reset.
// ----------------------------------------------------------------------------
// sphere_point_rotate_project_top
// Rotates a lat/lon sphere point by yaw, pitch and roll and projects it
// orthographically to screen coordinates with a visibility flag.
// ----------------------------------------------------------------------------
`include "sphere_point_rotate_project_top_macros.svh"

module sphere_point_rotate_project_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [spr_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0]   wr_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [spr_pkg::IN_DATA_W-1:0]    s_tdata,   // lat_index, lon_index
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [spr_pkg::OUT_DATA_W-1:0]   m_tdata,   // screen_x, screen_y
  output logic                             m_tuser    // visible
);

  logic             f_valid;
  logic             q_in_ready;
  spr_pkg::point_t  f_item;
  logic             q_valid;
  logic             bk_ready;
  spr_pkg::point_t  q_item;
  spr_pkg::cfg_wr_t cfg;

  assign cfg.en    = wr_en;
  assign cfg.index = wr_index;
  assign cfg.data  = wr_data;

  spr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (f_valid),
    .push_ready (q_in_ready),
    .push_item  (f_item)
  );

  spr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (q_in_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (bk_ready),
    .out_item  (q_item)
  );

  spr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (q_valid),
    .in_ready (bk_ready),
    .in_item  (q_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // front only backs up when it holds a point the full queue cannot take
  `SPR_ASSERT(a_front_stall, !s_tready |-> (f_valid && !q_in_ready))
  // back end only refuses the queue while a result is held at the output
  `SPR_ASSERT(a_back_stall, !bk_ready |-> (m_tvalid && !m_tready))
  // nothing left in flight right after reset
  `SPR_ASSERT(a_reset_empty, $past(rst) |-> (!q_valid && !m_tvalid && !f_valid))
  // an empty queue always has room
  `SPR_ASSERT_NEVER(a_queue_room, !q_valid && !q_in_ready)

endmodule

// File: tb/sphere_point_rotate_project_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_point_rotate_project_top_tb
// Streams lat/lon index pairs through the block under several yaw/pitch/roll
// settings and checks every screen x/y and visible flag against a Q14
// fixed-point prediction built from its own trig tables.
// ----------------------------------------------------------------------------
module sphere_point_rotate_project_top_tb;

  localparam int IDX_W      = spr_pkg::IDX_W;
  localparam int SCREEN_W   = spr_pkg::SCREEN_W;
  localparam int CFG_IDX_W  = spr_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = spr_pkg::CFG_DATA_W;
  localparam int IN_DATA_W  = spr_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = spr_pkg::OUT_DATA_W;
  localparam logic [CFG_IDX_W-1:0] REG_YAW   = spr_pkg::REG_YAW;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH = spr_pkg::REG_PITCH;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL  = spr_pkg::REG_ROLL;

  localparam int N_ANGLES       = 256;
  localparam int SCREEN_PIXELS  = 128;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int SETTLE_CYCLES  = 16;
  localparam int LONG_STALL     = 150;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RAND_PHASES    = 10;
  localparam int ITEMS_PER_PH   = 55;

  typedef struct packed {
    logic [SCREEN_W-1:0] sx;
    logic [SCREEN_W-1:0] sy;
    logic                vis;
  } screen_point_t;

  class point_projection_checker;
    shortint             sin_tab[N_ANGLES];
    shortint             cos_tab[N_ANGLES];
    logic [IDX_W-1:0]    yaw;
    logic [IDX_W-1:0]    pitch;
    logic [IDX_W-1:0]    roll;
    screen_point_t       pending_points[$];
    int                  errors;

    function new();
      yaw    = '0;
      pitch  = '0;
      roll   = '0;
      errors = 0;
      for (int i = 0; i < N_ANGLES; i++) fill_entry(i);
    endfunction

    // Taylor series in Q30 on an angle folded into the first quadrant (2*3.14 turn)
    function void fill_entry(int unsigned i);
      longint unsigned ang;
      longint unsigned ts;
      longint unsigned tc;
      longint unsigned a;
      longint          ssum;
      longint          csum;
      longint          ms;
      longint          mc;
      bit              sneg;
      bit              cneg;
      ang  = ((64'(i) * 64'd628) << 30) / (64'd100 * 64'(N_ANGLES));
      sneg = 1'b0;
      cneg = 1'b0;
      if (ang >= 64'd3373259426) begin
        ang  = ang - 64'd3373259426;
        sneg = ~sneg;
        cneg = ~cneg;
      end
      if (ang > 64'd1686629713) begin
        ang  = 64'd3373259426 - ang;
        cneg = ~cneg;
      end
      ts   = ang;
      tc   = 64'd1073741824;
      ssum = $signed(ts);
      csum = $signed(tc);
      for (int k = 1; k < 12; k++) begin
        a  = 64'(2 * k);
        ts = (ts * ang) >> 30;
        ts = ((ts * ang) >> 30) / (a * (a + 64'd1));
        tc = (tc * ang) >> 30;
        tc = ((tc * ang) >> 30) / ((a - 64'd1) * a);
        if (k % 2 == 1) begin
          ssum = ssum - $signed(ts);
          csum = csum - $signed(tc);
        end else begin
          ssum = ssum + $signed(ts);
          csum = csum + $signed(tc);
        end
      end
      if (ssum < 0) ssum = 0;
      if (csum < 0) csum = 0;
      ms = $signed(($unsigned(ssum) + 64'd32768) >> 16);
      mc = $signed(($unsigned(csum) + 64'd32768) >> 16);
      sin_tab[i] = shortint'(sneg ? -ms : ms);
      cos_tab[i] = shortint'(cneg ? -mc : mc);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_YAW:   yaw   = val;
        REG_PITCH: pitch = val;
        REG_ROLL:  roll  = val;
        default: ;
      endcase
    endfunction

    // floor((v + 2^13) / 2^14)
    function longint round_q14(longint v);
      return (v + 64'sd8192) >>> 14;
    endfunction

    function logic [SCREEN_W-1:0] to_screen(longint v);
      longint t;
      longint q;
      t = (v + 64'sd16384) * SCREEN_PIXELS;
      if (t < 0) return '0;
      q = t >>> 15;
      if (q > SCREEN_PIXELS) q = SCREEN_PIXELS;
      return SCREEN_W'(q);
    endfunction

    function screen_point_t predict_screen_point(logic [IDX_W-1:0] lat, logic [IDX_W-1:0] lon);
      longint sla, cla, slo, clo, sy, cy, sp, cp, sr, cr;
      longint x1, y1, z1, x2, z2, y3, z3, x4, y4;
      screen_point_t r;
      sla = sin_tab[lat % N_ANGLES];   cla = cos_tab[lat % N_ANGLES];
      slo = sin_tab[lon % N_ANGLES];   clo = cos_tab[lon % N_ANGLES];
      sy  = sin_tab[yaw % N_ANGLES];   cy  = cos_tab[yaw % N_ANGLES];
      sp  = sin_tab[pitch % N_ANGLES]; cp  = cos_tab[pitch % N_ANGLES];
      sr  = sin_tab[roll % N_ANGLES];  cr  = cos_tab[roll % N_ANGLES];
      x1 = round_q14(slo * cla);
      y1 = sla;
      z1 = round_q14(clo * cla);
      x2 = round_q14(x1 * cy + z1 * sy);
      z2 = round_q14(z1 * cy - x1 * sy);
      y3 = round_q14(y1 * cp + z2 * sp);
      z3 = round_q14(z2 * cp - y1 * sp);
      x4 = round_q14(x2 * cr + y3 * sr);
      y4 = round_q14(y3 * cr - x2 * sr);
      r.sx  = to_screen(x4);
      r.sy  = to_screen(y4);
      r.vis = (z3 >= 0);
      return r;
    endfunction

    function void note_point(logic [IDX_W-1:0] lat, logic [IDX_W-1:0] lon);
      pending_points.push_back(predict_screen_point(lat, lon));
    endfunction

    function void check_point(logic [SCREEN_W-1:0] sx, logic [SCREEN_W-1:0] sy, logic vis);
      screen_point_t e;
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d visible=%0d", $time, sx, sy, vis);
        errors++;
        return;
      end
      e = pending_points.pop_front();
      if (sx !== e.sx) begin
        $display("%0t: screen_x mismatch: expected %0d, actual %0d", $time, e.sx, sx);
        errors++;
      end
      if (sy !== e.sy) begin
        $display("%0t: screen_y mismatch: expected %0d, actual %0d", $time, e.sy, sy);
        errors++;
      end
      if (vis !== e.vis) begin
        $display("%0t: visible mismatch: expected %0d, actual %0d", $time, e.vis, vis);
        errors++;
      end
    endfunction

    function int pending();
      return pending_points.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // lat_index, lon_index
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // screen_x, screen_y
  logic                  m_tuser;   // visible

  point_projection_checker chk;
  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          hold_request;
  int unsigned quiet_cycles;

  sphere_point_rotate_project_top dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // transfer monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) chk.note_point(s_tdata[IDX_W-1:0], s_tdata[2*IDX_W-1:IDX_W]);
      if (m_tvalid && m_tready)
        chk.check_point(m_tdata[SCREEN_W-1:0], m_tdata[2*SCREEN_W-1:SCREEN_W], m_tuser);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    repeat (12) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_point(input logic [IDX_W-1:0] lat, input logic [IDX_W-1:0] lon);
    s_tvalid <= 1'b1;
    s_tdata  <= {lon, lat};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic sender_gap(input int n);
    s_tvalid <= 1'b0;
    s_tdata  <= IN_DATA_W'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (tx_idle_on && $urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 18));
  endtask

  // wait out every outstanding result, then let the pipe settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (chk.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_angles(input logic [CFG_DATA_W-1:0] y, input logic [CFG_DATA_W-1:0] p,
                            input logic [CFG_DATA_W-1:0] r);
    logic [CFG_IDX_W-1:0]  regs[4];
    logic [CFG_DATA_W-1:0] vals[4];
    regs = '{REG_UNUSED, REG_YAW, REG_PITCH, REG_ROLL};
    vals = '{CFG_DATA_W'($urandom), y, p, r};
    wr_en <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      wr_index <= regs[i];
      wr_data  <= vals[i];
      @(posedge clk);
      chk.set_reg(regs[i], vals[i]);
    end
    wr_en <= 1'b0;
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    logic [IDX_W-1:0] corners[5];
    corners = '{8'd0, 8'd64, 8'd128, 8'd192, 8'd255};
    if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 4)];
    return IDX_W'($urandom_range(0, 255));
  endfunction

  initial begin
    logic [IDX_W-1:0] dir_lat[12];
    logic [IDX_W-1:0] dir_lon[12];
    chk          = new();
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    hold_request = 1'b0;
    rst      <= 1'b1;
    wr_en    <= 1'b0;
    wr_index <= '0;
    wr_data  <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // poles, equator, wrap ends and alternating bit patterns
    dir_lat = '{8'd0, 8'd255, 8'd0,   8'd255, 8'd64, 8'd0,
                8'd128, 8'd192, 8'd170, 8'd85, 8'd1, 8'd127};
    dir_lon = '{8'd0, 8'd255, 8'd255, 8'd0,   8'd0,  8'd64,
                8'd128, 8'd192, 8'd85,  8'd170, 8'd254, 8'd128};
    for (int i = 0; i < 12; i++) begin
      send_point(dir_lat[i], dir_lon[i]);
      maybe_gap();
    end
    drain_results();

    set_angles(8'd255, 8'd255, 8'd255);
    for (int i = 0; i < 8; i++) begin
      send_point(dir_lat[i], dir_lon[i]);
      maybe_gap();
    end
    drain_results();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       set_angles(8'd0, 8'd0, 8'd0);
        1:       set_angles(8'd255, 8'd0, 8'd128);
        2:       set_angles(8'd64, 8'd64, 8'd64);
        default: set_angles(pick_index(), pick_index(), pick_index());
      endcase
      tx_idle_on = !(ph == 5 || ph == RAND_PHASES - 1);
      rx_idle_on = tx_idle_on;
      if (ph == 3) begin
        // sink holds off while the source keeps pushing back to back
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++) send_point(pick_index(), pick_index());
        for (int i = 40; i < ITEMS_PER_PH; i++) begin
          send_point(pick_index(), pick_index());
          maybe_gap();
        end
      end else begin
        for (int i = 0; i < ITEMS_PER_PH; i++) begin
          send_point(pick_index(), pick_index());
          maybe_gap();
        end
      end
      drain_results();
    end

    if (chk.pending() != 0)
      $display("%0t: %0d results never arrived", $time, chk.pending());
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
